// ===== rtl/core/hsec_pkg.sv =====
// ----------------------------------------------------------------------------
// hsec_pkg
// Types and constants shared by the Hamming single-error corrector.
// ----------------------------------------------------------------------------
package hsec_pkg;

  localparam int WORD_W      = 63;  // code positions 1..63
  localparam int POS_W       = 6;   // syndrome / position width
  localparam int LEN_W       = 6;   // code length register width
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    STATUS_NONE          = 2'd0,
    STATUS_CORRECTED     = 2'd1,
    STATUS_UNCORRECTABLE = 2'd2
  } status_t;

  // one classified item between front and back
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [POS_W-1:0]  syn;
    status_t           status;
  } entry_t;

endpackage

// ===== rtl/core/hsec_front.sv =====
// ----------------------------------------------------------------------------
// hsec_front
// Accepts received words, masks them to the code length, forms the syndrome
// and classifies each item before it enters the queue.
// ----------------------------------------------------------------------------
module hsec_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [hsec_pkg::LEN_W-1:0]  eff_len,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hsec_pkg::WORD_W-1:0] in_word,
  output logic                        push_valid,
  input  logic                        push_ready,
  output hsec_pkg::entry_t            push_entry
);

  // positions whose index has bit b set
  function automatic logic [hsec_pkg::WORD_W-1:0] check_mask(input int b);
    logic [hsec_pkg::WORD_W-1:0] m;
    m = '0;
    for (int k = 0; k < hsec_pkg::WORD_W; k++) begin
      m[k] = (((k + 1) >> b) & 1) != 0;
    end
    return m;
  endfunction

  logic                        valid_r, valid_nxt;
  logic [hsec_pkg::WORD_W-1:0] word_r, word_nxt;
  logic [hsec_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [hsec_pkg::WORD_W-1:0] len_mask;
  logic [hsec_pkg::POS_W-1:0]  syn;
  logic                        take;

  assign in_ready = !valid_r || push_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    for (int k = 0; k < hsec_pkg::WORD_W; k++) begin
      len_mask[k] = eff_len > hsec_pkg::LEN_W'(k);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    word_nxt  = word_r;
    len_nxt   = len_r;
    if (take) begin
      valid_nxt = 1'b1;
      word_nxt  = in_word & len_mask;
      len_nxt   = eff_len;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    word_r <= word_nxt;
    len_r  <= len_nxt;
  end

  // each syndrome bit is one parity check over the masked word
  always_comb begin
    for (int b = 0; b < hsec_pkg::POS_W; b++) begin
      syn[b] = ^(word_r & check_mask(b));
    end
  end

  always_comb begin
    push_entry.word = word_r;
    push_entry.syn  = syn;
    if (syn == '0) begin
      push_entry.status = hsec_pkg::STATUS_NONE;
    end else if (syn <= len_r) begin
      push_entry.status = hsec_pkg::STATUS_CORRECTED;
    end else begin
      push_entry.status = hsec_pkg::STATUS_UNCORRECTABLE;
    end
  end

  assign push_valid = valid_r;

endmodule

// ===== rtl/core/hsec_queue.sv =====
// ----------------------------------------------------------------------------
// hsec_queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module hsec_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  hsec_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output hsec_pkg::entry_t pop_entry
);

  localparam int CNT_W = $clog2(hsec_pkg::QUEUE_DEPTH + 1);

  hsec_pkg::entry_t              mem [hsec_pkg::QUEUE_DEPTH];
  logic [hsec_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hsec_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          do_push, do_pop;

  assign push_ready = count_r != CNT_W'(hsec_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = mem[rd_ptr_r];

  function automatic logic [hsec_pkg::QUEUE_AW-1:0] ptr_inc(
    input logic [hsec_pkg::QUEUE_AW-1:0] p
  );
    logic [hsec_pkg::QUEUE_AW-1:0] n;
    n = p + 1'b1;
    if (p == hsec_pkg::QUEUE_AW'(hsec_pkg::QUEUE_DEPTH - 1)) begin
      n = '0;
    end
    return n;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/hsec_back.sv =====
// ----------------------------------------------------------------------------
// hsec_back
// Flips the erroneous position of corrected items and holds the result in
// an output register.
// ----------------------------------------------------------------------------
module hsec_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  hsec_pkg::entry_t            pop_entry,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hsec_pkg::WORD_W-1:0] out_word,
  output logic [hsec_pkg::POS_W-1:0]  out_syn,
  output hsec_pkg::status_t           out_status
);

  logic                        valid_r, valid_nxt;
  logic [hsec_pkg::WORD_W-1:0] word_r, word_nxt;
  logic [hsec_pkg::POS_W-1:0]  syn_r, syn_nxt;
  hsec_pkg::status_t           status_r, status_nxt;
  logic [hsec_pkg::WORD_W-1:0] flip;
  logic                        take;

  assign pop_ready = !valid_r || out_ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    for (int k = 0; k < hsec_pkg::WORD_W; k++) begin
      flip[k] = (pop_entry.status == hsec_pkg::STATUS_CORRECTED) &&
                (pop_entry.syn == hsec_pkg::POS_W'(k + 1));
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    word_nxt   = word_r;
    syn_nxt    = syn_r;
    status_nxt = status_r;
    if (take) begin
      valid_nxt  = 1'b1;
      word_nxt   = pop_entry.word ^ flip;
      syn_nxt    = pop_entry.syn;
      status_nxt = pop_entry.status;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    word_r   <= word_nxt;
    syn_r    <= syn_nxt;
    status_r <= status_nxt;
  end

  assign out_valid  = valid_r;
  assign out_word   = word_r;
  assign out_syn    = syn_r;
  assign out_status = status_r;

endmodule

// ===== rtl/core/hamming_single_error_corrector_unit.sv =====
// Hamming single-error corrector: one received word is accepted per clock and
// one result leaves per clock when the output side keeps up; each accepted item
// passes through the front register, the two-entry queue and the output
// register. The front masks the word to the code length and forms
// the syndrome with a fixed XOR tree; the back flips the named position.
// code_length may only be changed while no item is in flight; values above
// MAX_CODE_LEN are clamped to it.
// ----------------------------------------------------------------------------
// hamming_single_error_corrector_unit
// Top level: configuration register, front, queue and back part.
// ----------------------------------------------------------------------------
module hamming_single_error_corrector_unit #(
  parameter int MAX_CODE_LEN = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,     // code_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,      // [62:0] received_word, [63] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,     // [62:0] corrected_word, [68:63] error_position
  output logic [1:0]  out_tuser      // [1:0] status
);

  localparam logic [hsec_pkg::LEN_W-1:0] LEN_MAX = hsec_pkg::LEN_W'(MAX_CODE_LEN);
  localparam logic [hsec_pkg::LEN_W-1:0] LEN_RESET = hsec_pkg::LEN_W'(7);

  logic [hsec_pkg::LEN_W-1:0]  code_length_r, code_length_nxt;
  logic [hsec_pkg::LEN_W-1:0]  eff_len;
  logic                        push_valid, push_ready;
  logic                        pop_valid, pop_ready;
  hsec_pkg::entry_t            push_entry, pop_entry;
  logic [hsec_pkg::WORD_W-1:0] out_word;
  logic [hsec_pkg::POS_W-1:0]  out_syn;
  hsec_pkg::status_t           out_status;

  assign code_length_nxt = cfg_we ? cfg_wdata : code_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_length_r <= LEN_RESET;
    end else begin
      code_length_r <= code_length_nxt;
    end
  end

  assign eff_len = (code_length_r > LEN_MAX) ? LEN_MAX : code_length_r;

  hsec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_len    (eff_len),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_word    (in_tdata[hsec_pkg::WORD_W-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  hsec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  hsec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_word   (out_word),
    .out_syn    (out_syn),
    .out_status (out_status)
  );

  assign out_tdata = {3'b000, out_syn, out_word};
  assign out_tuser = out_status;

endmodule
